// ===== hw/rtl/jmq_pkg.sv =====
`timescale 1ns / 1ps
// jmq_pkg: widths, fixed-point constants and stage record types for the
// joint matrix pipeline; no dependencies

package jmq_pkg;

  localparam int QUAT_W  = 16;                 // signed Q1.14
  localparam int SCALE_W = 16;                 // signed Q7.8
  localparam int POS_W   = 32;                 // signed Q15.16
  localparam int OUT_W   = 32;                 // signed Q15.16
  localparam int PROD_W  = 2 * QUAT_W;         // component product, Q.28
  localparam int ENT_W   = PROD_W + 2;         // unscaled entry, Q.28
  localparam int MUL_W   = ENT_W + SCALE_W;    // scaled entry, Q.36
  localparam int SUM_W   = MUL_W + 1;          // after rounding bias
  localparam int SHIFT   = 20;                 // Q.36 down to Q.16
  localparam int N_ENT   = 9;

  localparam logic signed [ENT_W-1:0] Q28_ONE    = ENT_W'(64'sd268435456);
  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(64'sd524288);
  localparam logic signed [SUM_W-1:0] SAT_MAX    = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] SAT_MIN    = SUM_W'(-64'sd2147483648);

  // stage 1: quaternion component products
  typedef struct packed {
    logic signed [PROD_W-1:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
    logic [2:0][SCALE_W-1:0]  scale;
    logic [2:0][POS_W-1:0]    pos;
  } prod_stage_t;

  // stage 2: unscaled rotation entries, row major
  typedef struct packed {
    logic [N_ENT-1:0][ENT_W-1:0] ent;
    logic [2:0][SCALE_W-1:0]     scale;
    logic [2:0][POS_W-1:0]       pos;
  } ent_stage_t;

  // stage 3: entries times column scale
  typedef struct packed {
    logic [N_ENT-1:0][MUL_W-1:0] mul;
    logic [2:0][POS_W-1:0]       pos;
  } mul_stage_t;

  // round to nearest (ties up), then clamp to the 32 bit range
  function automatic logic [OUT_W-1:0] round_sat(input logic signed [MUL_W-1:0] p);
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] q;
    logic [OUT_W-1:0]        r;
    sum = SUM_W'(p) + ROUND_HALF;
    q   = sum >>> SHIFT;
    if (q > SAT_MAX) begin
      r = SAT_MAX[OUT_W-1:0];
    end else if (q < SAT_MIN) begin
      r = SAT_MIN[OUT_W-1:0];
    end else begin
      r = q[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/joint_matrix_from_quaternion.sv =====
`timescale 1ns / 1ps
// joint_matrix_from_quaternion: scaled 3x4 joint matrix from quaternion,
// position and scale; four-stage pipeline; uses jmq_pkg
//
// channel  | handshake        | payload
// ---------+------------------+--------------------------------------------
// request  | start, busy      | quat_x/y/z/w, pos_x/y/z, scale_x/y/z
// result   | done (1 cycle)   | m00..m22, trans_x/y/z
//
// one request per cycle; each request passes through the four register
// stages (products, entries, scale multiply, round and clamp), and done
// rises together with the result as it leaves the last of them
// busy is always low: the pipeline never has to hold off a request
// rst is synchronous and clears the stage valid bits only
// the receiver takes every result in the cycle done is high; nothing stalls

module joint_matrix_from_quaternion (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [jmq_pkg::QUAT_W-1:0]  quat_x,
  input  logic signed [jmq_pkg::QUAT_W-1:0]  quat_y,
  input  logic signed [jmq_pkg::QUAT_W-1:0]  quat_z,
  input  logic signed [jmq_pkg::QUAT_W-1:0]  quat_w,
  input  logic signed [jmq_pkg::POS_W-1:0]   pos_x,
  input  logic signed [jmq_pkg::POS_W-1:0]   pos_y,
  input  logic signed [jmq_pkg::POS_W-1:0]   pos_z,
  input  logic signed [jmq_pkg::SCALE_W-1:0] scale_x,
  input  logic signed [jmq_pkg::SCALE_W-1:0] scale_y,
  input  logic signed [jmq_pkg::SCALE_W-1:0] scale_z,
  output logic                               done,
  output logic signed [jmq_pkg::OUT_W-1:0]   m00,
  output logic signed [jmq_pkg::OUT_W-1:0]   m01,
  output logic signed [jmq_pkg::OUT_W-1:0]   m02,
  output logic signed [jmq_pkg::OUT_W-1:0]   m10,
  output logic signed [jmq_pkg::OUT_W-1:0]   m11,
  output logic signed [jmq_pkg::OUT_W-1:0]   m12,
  output logic signed [jmq_pkg::OUT_W-1:0]   m20,
  output logic signed [jmq_pkg::OUT_W-1:0]   m21,
  output logic signed [jmq_pkg::OUT_W-1:0]   m22,
  output logic signed [jmq_pkg::OUT_W-1:0]   trans_x,
  output logic signed [jmq_pkg::OUT_W-1:0]   trans_y,
  output logic signed [jmq_pkg::OUT_W-1:0]   trans_z
);

  // stage valid bits travel alongside the data
  logic v1, v2, v3, v4;
  logic take;

  jmq_pkg::prod_stage_t s1, s1_next;
  jmq_pkg::ent_stage_t  s2, s2_next;
  jmq_pkg::mul_stage_t  s3, s3_next;
  logic [jmq_pkg::N_ENT-1:0][jmq_pkg::OUT_W-1:0] res, res_next;
  logic [2:0][jmq_pkg::POS_W-1:0] pos4;

  assign busy = 1'b0;
  assign take = start && !busy;

  // ---------------------------------------------------------------------------
  // stage 1: the nine distinct component products, each exact in Q.28
  // ---------------------------------------------------------------------------
  always_comb begin
    s1_next.xx    = jmq_pkg::PROD_W'(quat_x) * jmq_pkg::PROD_W'(quat_x);
    s1_next.yy    = jmq_pkg::PROD_W'(quat_y) * jmq_pkg::PROD_W'(quat_y);
    s1_next.zz    = jmq_pkg::PROD_W'(quat_z) * jmq_pkg::PROD_W'(quat_z);
    s1_next.xy    = jmq_pkg::PROD_W'(quat_x) * jmq_pkg::PROD_W'(quat_y);
    s1_next.xz    = jmq_pkg::PROD_W'(quat_x) * jmq_pkg::PROD_W'(quat_z);
    s1_next.yz    = jmq_pkg::PROD_W'(quat_y) * jmq_pkg::PROD_W'(quat_z);
    s1_next.wx    = jmq_pkg::PROD_W'(quat_w) * jmq_pkg::PROD_W'(quat_x);
    s1_next.wy    = jmq_pkg::PROD_W'(quat_w) * jmq_pkg::PROD_W'(quat_y);
    s1_next.wz    = jmq_pkg::PROD_W'(quat_w) * jmq_pkg::PROD_W'(quat_z);
    s1_next.scale = {scale_z, scale_y, scale_x};
    s1_next.pos   = {pos_z, pos_y, pos_x};
  end

  // ---------------------------------------------------------------------------
  // stage 2: rotation entries, row major; doubling is a left shift, and the
  // 34 bit width holds the worst case of an unnormalized quaternion
  // ---------------------------------------------------------------------------
  always_comb begin
    logic signed [jmq_pkg::ENT_W-1:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
    xx = jmq_pkg::ENT_W'(s1.xx);
    yy = jmq_pkg::ENT_W'(s1.yy);
    zz = jmq_pkg::ENT_W'(s1.zz);
    xy = jmq_pkg::ENT_W'(s1.xy);
    xz = jmq_pkg::ENT_W'(s1.xz);
    yz = jmq_pkg::ENT_W'(s1.yz);
    wx = jmq_pkg::ENT_W'(s1.wx);
    wy = jmq_pkg::ENT_W'(s1.wy);
    wz = jmq_pkg::ENT_W'(s1.wz);
    s2_next.ent[0] = jmq_pkg::Q28_ONE - ((yy + zz) <<< 1);
    s2_next.ent[1] = (xy - wz) <<< 1;
    s2_next.ent[2] = (xz + wy) <<< 1;
    s2_next.ent[3] = (xy + wz) <<< 1;
    s2_next.ent[4] = jmq_pkg::Q28_ONE - ((xx + zz) <<< 1);
    s2_next.ent[5] = (yz - wx) <<< 1;
    s2_next.ent[6] = (xz - wy) <<< 1;
    s2_next.ent[7] = (yz + wx) <<< 1;
    s2_next.ent[8] = jmq_pkg::Q28_ONE - ((xx + yy) <<< 1);
    s2_next.scale  = s1.scale;
    s2_next.pos    = s1.pos;
  end

  // ---------------------------------------------------------------------------
  // stage 3: one 34x16 multiply per entry, column c takes scale c
  // ---------------------------------------------------------------------------
  always_comb begin
    logic signed [jmq_pkg::MUL_W-1:0] e_ext;
    logic signed [jmq_pkg::MUL_W-1:0] s_ext;
    for (int i = 0; i < jmq_pkg::N_ENT; i++) begin
      e_ext = jmq_pkg::MUL_W'($signed(s2.ent[i]));
      s_ext = jmq_pkg::MUL_W'($signed(s2.scale[i % 3]));
      s3_next.mul[i] = e_ext * s_ext;
    end
    s3_next.pos = s2.pos;
  end

  // ---------------------------------------------------------------------------
  // stage 4: round Q.36 to Q15.16 and clamp
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < jmq_pkg::N_ENT; i++) begin
      res_next[i] = jmq_pkg::round_sat($signed(s3.mul[i]));
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    s1   <= s1_next;
    s2   <= s2_next;
    s3   <= s3_next;
    res  <= res_next;
    pos4 <= s3.pos;
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= take;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  assign done    = v4;
  assign m00     = res[0];
  assign m01     = res[1];
  assign m02     = res[2];
  assign m10     = res[3];
  assign m11     = res[4];
  assign m12     = res[5];
  assign m20     = res[6];
  assign m21     = res[7];
  assign m22     = res[8];
  assign trans_x = pos4[0];
  assign trans_y = pos4[1];
  assign trans_z = pos4[2];

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------

  // every result comes from a request taken at the pipeline input
  a_done_from_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(take, 4))
    else $error("result without a matching request");

  // translation x and z entries travel with their own request
  a_trans_aligned: assert property (@(posedge clk) disable iff (rst)
    done |-> (trans_x == $past(pos_x, 4)) && (trans_z == $past(pos_z, 4)))
    else $error("translation out of step with rotation");

  // a zero scale_y gives a zero middle column (m01, m11, m21)
  a_zero_scale_col: assert property (@(posedge clk) disable iff (rst)
    (done && $past(scale_y == '0, 4)) |-> (m01 == '0) && (m11 == '0) && (m21 == '0))
    else $error("column scale applied to the wrong column");

endmodule

// ===== sim/joint_matrix_from_quaternion_test.sv =====
`timescale 1ns / 1ps
// joint_matrix_from_quaternion_test: self-checking bench for the joint matrix
// pipeline, with its own fixed-point predictor and an in-order scoreboard;
// depends on jmq_pkg and joint_matrix_from_quaternion

module joint_matrix_from_quaternion_test;

  localparam int CLK_HALF   = 6;       // 12 ns period
  localparam int RST_CYCLES = 11;
  localparam int RAND_REQS  = 550;
  localparam int IDLE_PCT   = 35;      // share of cycles with start low
  localparam int DRAIN_WAIT = 8;       // pipeline is four stages deep
  localparam int CYCLE_CAP  = 50000;   // far above the slowest correct run

  // one request as the sender sees it
  typedef struct packed {
    logic signed [jmq_pkg::QUAT_W-1:0]  qx, qy, qz, qw;
    logic signed [jmq_pkg::POS_W-1:0]   px, py, pz;
    logic signed [jmq_pkg::SCALE_W-1:0] sx, sy, sz;
  } pose_req_t;

  // one 3x4 result, index 0..8 = m00..m22 row major, 9..11 = trans_x/y/z
  typedef logic [11:0][jmq_pkg::OUT_W-1:0] joint_mat_t;

  // predicts each joint matrix at request time and checks results in order
  class joint_scoreboard;
    localparam longint UNIT_Q28   = 64'sd268435456;   // 1.0 in Q.28
    localparam longint ROUND_BIAS = 64'sd524288;      // half of the lowest kept bit
    localparam int     FRAC_DROP  = 20;               // Q.36 down to Q.16
    localparam longint SAT_HI     = 64'sd2147483647;
    localparam longint SAT_LO     = -64'sd2147483648;

    joint_mat_t expected_q[$];
    int errors   = 0;
    int reported = 0;

    function void note_request(pose_req_t r);
      longint x, y, z, w;
      longint s[3];
      longint ent[9];
      longint p, v;
      joint_mat_t m;
      x = longint'($signed(r.qx));
      y = longint'($signed(r.qy));
      z = longint'($signed(r.qz));
      w = longint'($signed(r.qw));
      s[0] = longint'($signed(r.sx));
      s[1] = longint'($signed(r.sy));
      s[2] = longint'($signed(r.sz));
      // rotation matrix straight from the quaternion, no normalization
      ent[0] = UNIT_Q28 - 2 * (y * y + z * z);
      ent[1] = 2 * (x * y - w * z);
      ent[2] = 2 * (x * z + w * y);
      ent[3] = 2 * (x * y + w * z);
      ent[4] = UNIT_Q28 - 2 * (x * x + z * z);
      ent[5] = 2 * (y * z - w * x);
      ent[6] = 2 * (x * z - w * y);
      ent[7] = 2 * (y * z + w * x);
      ent[8] = UNIT_Q28 - 2 * (x * x + y * y);
      for (int i = 0; i < 9; i++) begin
        p = ent[i] * s[i % 3];
        v = (p + ROUND_BIAS) >>> FRAC_DROP;   // round half up
        if (v > SAT_HI) begin
          v = SAT_HI;
        end else if (v < SAT_LO) begin
          v = SAT_LO;
        end
        m[i] = v[jmq_pkg::OUT_W-1:0];
      end
      m[9]  = r.px;
      m[10] = r.py;
      m[11] = r.pz;
      expected_q.push_back(m);
    endfunction

    function void check_result(joint_mat_t got);
      joint_mat_t want;
      string axes;
      axes = "xyz";
      if (expected_q.size() == 0) begin
        errors++;
        if (reported < 10) begin
          $display("result with no request pending at %0t", $realtime);
        end
        reported++;
        return;
      end
      want = expected_q.pop_front();
      for (int i = 0; i < 12; i++) begin
        if (got[i] !== want[i]) begin
          errors++;
          if (reported < 10) begin
            if (i < 9) begin
              $display("m%0d%0d mismatch: expected %0d got %0d", i / 3, i % 3,
                       $signed(want[i]), $signed(got[i]));
            end else begin
              $display("trans_%c mismatch: expected %0d got %0d", axes[i - 9],
                       $signed(want[i]), $signed(got[i]));
            end
          end
          reported++;
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic signed [jmq_pkg::QUAT_W-1:0]  quat_x, quat_y, quat_z, quat_w;
  logic signed [jmq_pkg::POS_W-1:0]   pos_x, pos_y, pos_z;
  logic signed [jmq_pkg::SCALE_W-1:0] scale_x, scale_y, scale_z;
  logic done;
  logic signed [jmq_pkg::OUT_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  logic signed [jmq_pkg::OUT_W-1:0] trans_x, trans_y, trans_z;

  joint_scoreboard sb = new;
  int idle_pct;
  int cycle_count = 0;

  joint_matrix_from_quaternion dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .quat_x  (quat_x),
    .quat_y  (quat_y),
    .quat_z  (quat_z),
    .quat_w  (quat_w),
    .pos_x   (pos_x),
    .pos_y   (pos_y),
    .pos_z   (pos_z),
    .scale_x (scale_x),
    .scale_y (scale_y),
    .scale_z (scale_z),
    .done    (done),
    .m00     (m00),
    .m01     (m01),
    .m02     (m02),
    .m10     (m10),
    .m11     (m11),
    .m12     (m12),
    .m20     (m20),
    .m21     (m21),
    .m22     (m22),
    .trans_x (trans_x),
    .trans_y (trans_y),
    .trans_z (trans_z)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // hard stop in case the pipeline hangs or drops results
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: done lasts one cycle and cannot be held off, so every
  // strobe seen at an edge is taken there; values read here are pre-edge
  always @(posedge clk) begin
    if (!rst && done) begin
      sb.check_result({trans_z, trans_y, trans_x,
                       m22, m21, m20, m12, m11, m10, m02, m01, m00});
    end
  end

  function automatic pose_req_t make_req(int qx, int qy, int qz, int qw,
                                         int px, int py, int pz,
                                         int sx, int sy, int sz);
    pose_req_t r;
    r.qx = qx[jmq_pkg::QUAT_W-1:0];
    r.qy = qy[jmq_pkg::QUAT_W-1:0];
    r.qz = qz[jmq_pkg::QUAT_W-1:0];
    r.qw = qw[jmq_pkg::QUAT_W-1:0];
    r.px = px;
    r.py = py;
    r.pz = pz;
    r.sx = sx[jmq_pkg::SCALE_W-1:0];
    r.sy = sy[jmq_pkg::SCALE_W-1:0];
    r.sz = sz[jmq_pkg::SCALE_W-1:0];
    return r;
  endfunction

  // random request: mostly full-range fields, some near-unit rotations with
  // everyday scales so the typical skinning case is well exercised too
  function automatic pose_req_t rand_req();
    pose_req_t r;
    r.qx = jmq_pkg::QUAT_W'($urandom);
    r.qy = jmq_pkg::QUAT_W'($urandom);
    r.qz = jmq_pkg::QUAT_W'($urandom);
    r.qw = jmq_pkg::QUAT_W'($urandom);
    r.px = jmq_pkg::POS_W'($urandom);
    r.py = jmq_pkg::POS_W'($urandom);
    r.pz = jmq_pkg::POS_W'($urandom);
    r.sx = jmq_pkg::SCALE_W'($urandom);
    r.sy = jmq_pkg::SCALE_W'($urandom);
    r.sz = jmq_pkg::SCALE_W'($urandom);
    if ($urandom_range(99) < 40) begin
      r.qx = jmq_pkg::QUAT_W'($signed($urandom_range(16384)) - 8192);
      r.qy = jmq_pkg::QUAT_W'($signed($urandom_range(16384)) - 8192);
      r.qz = jmq_pkg::QUAT_W'($signed($urandom_range(16384)) - 8192);
      r.qw = jmq_pkg::QUAT_W'($signed($urandom_range(4096)) + 12288);
      r.sx = jmq_pkg::SCALE_W'($signed($urandom_range(1024)) - 512);
      r.sy = jmq_pkg::SCALE_W'($signed($urandom_range(1024)) - 512);
      r.sz = jmq_pkg::SCALE_W'($signed($urandom_range(1024)) - 512);
    end
    return r;
  endfunction

  // one request: random idle cycles with start low, then start high until
  // taken at an edge where busy is low; start gets one assignment per step
  task automatic drive_request(pose_req_t r);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    quat_x  <= r.qx;
    quat_y  <= r.qy;
    quat_z  <= r.qz;
    quat_w  <= r.qw;
    pos_x   <= r.px;
    pos_y   <= r.py;
    pos_z   <= r.pz;
    scale_x <= r.sx;
    scale_y <= r.sy;
    scale_z <= r.sz;
    do @(posedge clk); while (busy);
    sb.note_request(r);
  endtask

  initial begin
    rst     <= 1'b1;
    start   <= 1'b0;
    quat_x  <= '0;
    quat_y  <= '0;
    quat_z  <= '0;
    quat_w  <= '0;
    pos_x   <= '0;
    pos_y   <= '0;
    pos_z   <= '0;
    scale_x <= '0;
    scale_y <= '0;
    scale_z <= '0;
    idle_pct = IDLE_PCT;
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed part: identity, zero and unnormalized quaternions, quarter
    // and half turns, field extremes, zero and negative scales
    drive_request(make_req(0, 0, 0, 16384, 0, 0, 0, 256, 256, 256));
    drive_request(make_req(0, 0, 0, 0, 65536, -65536, 1, 256, 256, 256));
    drive_request(make_req(32767, 32767, 32767, 32767,
                           32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                           32767, 32767, 32767));
    drive_request(make_req(-32768, -32768, -32768, -32768,
                           32'h80000000, 32'h80000000, 32'h80000000,
                           -32768, -32768, -32768));
    drive_request(make_req(-32768, 32767, -32768, 32767,
                           32'h80000000, 32'h7fffffff, 0, 32767, -32768, 1));
    drive_request(make_req(32767, -32768, 32767, -32768,
                           -1, 0, 32'h7fffffff, -32768, 32767, -1));
    drive_request(make_req(0, 0, 11585, 11585, 12345, -54321, 0, 256, 256, 256));
    drive_request(make_req(16384, 0, 0, 0, 0, 0, 0, 256, 512, 128));
    drive_request(make_req(0, 16384, 0, 0, 0, 0, 0, 256, 256, 256));
    drive_request(make_req(0, 0, 16384, 0, 0, 0, 0, 256, 256, 256));
    drive_request(make_req(5000, -7000, 3000, 14000, 100, 200, 300, 0, 0, 0));
    drive_request(make_req(5000, -7000, 3000, 14000, 100, 200, 300, -256, -512, -128));
    drive_request(make_req(0, 0, 0, 32767, 0, 0, 0, 256, 256, 256));
    drive_request(make_req(20000, 20000, 20000, 20000, 7, 7, 7, 384, -384, 640));
    drive_request(make_req(16'h5555, 16'haaaa, 16'h5555, 16'haaaa,
                           32'h55555555, 32'haaaaaaaa, 32'h55555555,
                           16'haaaa, 16'h5555, 16'haaaa));
    drive_request(make_req(1, -1, 1, -1, 1, -1, 1, 1, -1, 1));
    drive_request(make_req(0, 0, 0, 16384, 0, 0, 0, 1, -1, 32767));

    // random part; a stretch in the middle runs back to back with no idling
    for (int n = 0; n < RAND_REQS; n++) begin
      idle_pct = (n >= 200 && n < 320) ? 0 : IDLE_PCT;
      drive_request(rand_req());
    end
    start <= 1'b0;

    // drain the pipeline, then leave room for any stray strobe
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
